### rtl/assert_macros.svh
// Assertion helpers for the assertion checker (agm_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/agm_pkg.sv
`default_nettype none
package agm_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_LIST  = 2'd2;

  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       adjacent;
    logic [5:0] neighbour;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_A,
    S_ADD_B,
    S_QUERY,
    S_LIST_LOAD,
    S_SCAN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch input word, read row a
    logic wr_a;       // write row a | bit b, read row b
    logic wr_b;       // write row b | bit a
    logic ans_emit;   // load adjacency answer into output register
    logic list_load;  // load scan register from row a
    logic scan_step;  // shift scan register, bump index
    logic list_emit;  // load neighbour entry into output register
    logic none_emit;  // load "no neighbours" into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       pair_ok;
    logic       out_free;
    logic       scan_bit;
    logic       scan_empty;
    logic       scan_last;
  } status_t;

endpackage
`default_nettype wire

### rtl/adjacency_matrix_graph_core.sv
`default_nettype none
// Undirected graph kept as a symmetric adjacency bit matrix, one row per
// vertex in a single-port-read, single-port-write memory; rows read as zero
// after reset through per-row valid flops, so no clearing pass is needed.
// Input words: add edge (no result), query (one answer word, last set) and
// list (one entry word per neighbour in ascending order, last on the final
// one, or a single "none" word). Indices at or above min(cfg count, MAX)
// are ignored / answer false / list "none". One word is in flight at a
// time. Steps per word follow from the one read and one write port and
// the bit-at-a-time neighbour scan: add reads a, then writes a while
// reading b, then writes b (no writes when the pair is dropped); query
// reads a, then loads the answer; list reads a, loads the scan register
// and steps through it (scan stops after the last neighbour); an unused
// op is only accepted. An output stall holds any emit. The result sits
// in an output register, so a new word is taken while the last result
// still waits. cfg_ready is always high; write only while idle.
module adjacency_matrix_graph_core
  import agm_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input words
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  // result words
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word,
  // vertex count register
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data
);

  cmd_t    cmd;
  status_t stat;

  assign cfg_ready = 1'b1;

  agm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  agm_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

### rtl/agm_ctrl.sv
`default_nettype none
module agm_ctrl
  import agm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t stat,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (stat.in_op)
            OP_ADD:   state_nxt = S_ADD_A;
            OP_QUERY: state_nxt = S_QUERY;
            OP_LIST:  state_nxt = S_LIST_LOAD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_A:     state_nxt = stat.pair_ok ? S_ADD_B : S_IDLE;
      S_ADD_B:     state_nxt = S_IDLE;
      S_QUERY:     state_nxt = stat.out_free ? S_IDLE : S_QUERY;
      S_LIST_LOAD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.out_free && (stat.scan_empty || (stat.scan_bit && stat.scan_last))) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_ADD_A:     cmd.wr_a = stat.pair_ok;
      S_ADD_B:     cmd.wr_b = 1'b1;
      S_QUERY:     cmd.ans_emit = stat.out_free;
      S_LIST_LOAD: cmd.list_load = 1'b1;
      S_SCAN: begin
        if (stat.scan_empty) begin
          cmd.none_emit = stat.out_free;
        end else if (stat.scan_bit) begin
          cmd.list_emit = stat.out_free;
          cmd.scan_step = stat.out_free;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/agm_dpath.sv
`default_nettype none
module agm_dpath
  import agm_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_word,
  input  wire logic      cfg_valid,
  input  wire logic [6:0] cfg_data,
  input  wire cmd_t      cmd,
  output status_t        stat,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  typedef logic [MAX_VERTICES-1:0] row_t;

  // adjacency rows and per-row valid bits (invalid row reads as zero)
  row_t mem [MAX_VERTICES];
  row_t vld_r;
  row_t rowq_r;
  logic rowq_vld_r;

  logic [6:0] vcount_r;
  logic [6:0] live_cnt;
  row_t       live_mask;

  logic [1:0] op_r;
  logic [5:0] a_r, b_r;
  logic       a_ok_r, b_ok_r;

  row_t          scan_r;
  logic [AW-1:0] j_r;

  logic      out_valid_r;
  out_word_t out_word_r;

  row_t          row_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  row_t          wr_data;
  logic          out_free;

  assign live_cnt = (vcount_r > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_r;

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      live_mask[k] = (7'(k) < live_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_valid) begin
      vcount_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_word.op;
      a_r    <= in_word.vertex_a;
      b_r    <= in_word.vertex_b;
      a_ok_r <= ({1'b0, in_word.vertex_a} < live_cnt);
      b_ok_r <= ({1'b0, in_word.vertex_b} < live_cnt);
    end
  end

  assign row_data = rowq_vld_r ? rowq_r : '0;

  // one read port, one write port
  assign rd_en   = cmd.accept || cmd.wr_a;
  assign rd_addr = cmd.accept ? in_word.vertex_a[AW-1:0] : b_r[AW-1:0];
  assign wr_en   = cmd.wr_a || cmd.wr_b;
  assign wr_addr = cmd.wr_a ? a_r[AW-1:0] : b_r[AW-1:0];
  assign wr_data = cmd.wr_a ? (row_data | (row_t'(1) << b_r[AW-1:0]))
                            : (row_data | (row_t'(1) << a_r[AW-1:0]));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rowq_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rowq_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rowq_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // neighbour scan, one bit a cycle unless a found neighbour waits for the output register
  always_ff @(posedge clk) begin
    if (cmd.list_load) begin
      scan_r <= a_ok_r ? (row_data & live_mask) : '0;
      j_r    <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r >> 1;
      j_r    <= j_r + 1'b1;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ans_emit || cmd.list_emit || cmd.none_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ans_emit) begin
      out_word_r.kind      <= KIND_ANSWER;
      out_word_r.adjacent  <= a_ok_r && b_ok_r && row_data[b_r[AW-1:0]];
      out_word_r.neighbour <= '0;
      out_word_r.last      <= 1'b1;
    end else if (cmd.list_emit) begin
      out_word_r.kind      <= KIND_ENTRY;
      out_word_r.adjacent  <= 1'b0;
      out_word_r.neighbour <= 6'(j_r);
      out_word_r.last      <= stat.scan_last;
    end else if (cmd.none_emit) begin
      out_word_r.kind      <= KIND_NONE;
      out_word_r.adjacent  <= 1'b0;
      out_word_r.neighbour <= '0;
      out_word_r.last      <= 1'b1;
    end
  end

  assign stat.in_op      = in_word.op;
  assign stat.pair_ok    = a_ok_r && b_ok_r && (op_r == OP_ADD);
  assign stat.out_free   = out_free;
  assign stat.scan_bit   = scan_r[0];
  assign stat.scan_empty = (scan_r == '0);
  assign stat.scan_last  = ((scan_r >> 1) == '0);

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

### rtl/agm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module agm_checker
  import agm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // held word stays put
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
  // answers and "none" are always the final word
  `ASSERT_IMPLY(a_single_last, clk, rst_n, out_valid && out_word.kind != KIND_ENTRY, out_word.last)
  // adjacency flag only on answers
  `ASSERT_IMPLY(a_adj_kind, clk, rst_n, out_valid && out_word.adjacent, out_word.kind == KIND_ANSWER)
  // neighbour index only on entries
  `ASSERT_IMPLY(a_nb_kind, clk, rst_n, out_valid && out_word.kind != KIND_ENTRY, out_word.neighbour == 6'd0)

endmodule

bind adjacency_matrix_graph_core agm_checker u_agm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

### tb/adjacency_result_checker.sv
`default_nettype none
// Watches the word, result and count channels of the graph core, keeps its own
// copy of the adjacency matrix and count, and checks every result word.
module adjacency_result_checker
  import agm_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire in_word_t   in_word,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire out_word_t  out_word,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [6:0] cfg_data,
  output int              words_due,
  output int              mismatches
);

  logic [63:0] adj_rows [MAX_VERTICES];
  logic [6:0]  vcount;
  out_word_t   due_q [$];

  initial begin
    mismatches = 0;
    words_due  = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t adjacency_result_checker: %s", $time, msg);
    mismatches++;
  endtask

  // Update the matrix copy and queue the result words one input word causes.
  function automatic void predict_results(input in_word_t w);
    int        live;
    int        first;
    bit        a_ok;
    bit        b_ok;
    out_word_t r;
    live = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
    a_ok = int'(w.vertex_a) < live;
    b_ok = int'(w.vertex_b) < live;
    r    = '0;
    case (w.op)
      OP_ADD: begin
        if (a_ok && b_ok) begin
          adj_rows[w.vertex_a][w.vertex_b] = 1'b1;
          adj_rows[w.vertex_b][w.vertex_a] = 1'b1;
        end
      end
      OP_QUERY: begin
        r.kind     = KIND_ANSWER;
        r.adjacent = a_ok && b_ok && adj_rows[w.vertex_a][w.vertex_b];
        r.last     = 1'b1;
        due_q.push_back(r);
      end
      OP_LIST: begin
        first = due_q.size();
        // bits at or above the live count are never listed
        if (a_ok) begin
          for (int j = 0; j < live; j++) begin
            if (adj_rows[w.vertex_a][j]) begin
              r.kind      = KIND_ENTRY;
              r.neighbour = 6'(j);
              due_q.push_back(r);
            end
          end
        end
        if (due_q.size() == first) begin
          r.kind = KIND_NONE;
          r.last = 1'b1;
          due_q.push_back(r);
        end else begin
          r      = due_q.pop_back();
          r.last = 1'b1;
          due_q.push_back(r);
        end
      end
      default: ;  // unused op: no result, no change
    endcase
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (due_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result word %h", got));
      return;
    end
    want = due_q.pop_front();
    if (got.kind != want.kind)
      flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.adjacent != want.adjacent)
      flag_mismatch($sformatf("adjacent %0d, expected %0d", got.adjacent, want.adjacent));
    if (got.neighbour != want.neighbour)
      flag_mismatch($sformatf("neighbour %0d, expected %0d", got.neighbour, want.neighbour));
    if (got.last != want.last)
      flag_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
  endtask

  // Results drain before new words are queued: a word's results never leave
  // on the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vcount = VCOUNT_RESET;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) check_word(out_word);
      if (cfg_valid && cfg_ready) vcount = cfg_data;
      if (in_valid && !in_stall) predict_results(in_word);
    end
    words_due = due_q.size();
  end

endmodule
`default_nettype wire

### tb/adjacency_matrix_graph_core_tb.sv
`default_nettype none
// Top of the graph core bench: drives words and count writes, randomly holds
// off both channels, and leaves all checking to the result checker.
module adjacency_matrix_graph_core_tb
  import agm_pkg::*;
();

  localparam int         MAX_VERTICES = 64;
  localparam logic [1:0] OP_UNUSED    = 2'd3;   // the block must ignore it
  localparam int         DRAIN_CYCLES = 16;     // a last add still writes in S_ADD_A and S_ADD_B
  localparam int         PHASE_WORDS  = 50;     // random words per count setting

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data  = '0;

  int words_due;
  int errors;
  int sent = 0;   // input words accepted so far

  // Windows with no hold-off at all, one per side.
  logic in_quiet;
  logic out_quiet;
  assign in_quiet  = (sent >= 150) && (sent < 260);
  assign out_quiet = (sent >= 280) && (sent < 390);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  adjacency_matrix_graph_core #(
    .MAX_VERTICES(MAX_VERTICES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  adjacency_result_checker #(
    .MAX_VERTICES(MAX_VERTICES)
  ) result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .words_due (words_due),
    .mismatches(errors)
  );

  // Receiver side: stall with odds of about 7 in 100, independent of out_valid.
  always @(posedge clk) begin
    out_stall <= !out_quiet && ($urandom_range(0, 99) < 7);
  end

  function automatic in_word_t word_of(input logic [1:0] op, input logic [5:0] a,
                                       input logic [5:0] b);
    in_word_t w;
    w.op       = op;
    w.vertex_a = a;
    w.vertex_b = b;
    return w;
  endfunction

  // Mostly in-range vertices so adds land and lists grow; one word in ten
  // uses the full 6-bit range to hit the out-of-range paths.
  function automatic in_word_t random_word(input int live);
    in_word_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    w.op = (roll < 40) ? OP_ADD : (roll < 70) ? OP_QUERY : (roll < 95) ? OP_LIST : OP_UNUSED;
    if (live > 0 && $urandom_range(0, 9) != 0) begin
      w.vertex_a = 6'($urandom_range(0, live - 1));
      w.vertex_b = 6'($urandom_range(0, live - 1));
    end else begin
      w.vertex_a = 6'($urandom_range(0, 63));
      w.vertex_b = 6'($urandom_range(0, 63));
    end
    return w;
  endfunction

  // Present one word and hold it until taken. An optional gap first drops
  // valid; otherwise valid stays high across words.
  task automatic send_word(input in_word_t w);
    if (!in_quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Let every expected result out, then give a trailing add time to finish.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Count writes happen only with the core idle.
  task automatic write_count(input logic [6:0] n);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         live;
    int         target;
    logic [5:0] hub;
    logic [6:0] n;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and each special case, count at its reset value.
    send_word(word_of(OP_ADD,    6'd0,  6'd63));
    send_word(word_of(OP_ADD,    6'd63, 6'd63));   // self loop
    send_word(word_of(OP_ADD,    6'd42, 6'd21));   // alternating bit patterns
    send_word(word_of(OP_QUERY,  6'd0,  6'd63));
    send_word(word_of(OP_QUERY,  6'd63, 6'd0));    // mirror bit
    send_word(word_of(OP_QUERY,  6'd63, 6'd63));
    send_word(word_of(OP_QUERY,  6'd21, 6'd0));
    send_word(word_of(OP_LIST,   6'd63, 6'd0));    // lists itself too
    send_word(word_of(OP_LIST,   6'd0,  6'd63));
    send_word(word_of(OP_LIST,   6'd5,  6'd0));    // no neighbours
    send_word(word_of(OP_UNUSED, 6'd63, 6'd63));
    send_word(word_of(OP_QUERY,  6'd42, 6'd21));

    // Count of one: vertex 0 only, old bit 63 of row 0 must stay hidden.
    write_count(7'd1);
    send_word(word_of(OP_ADD,    6'd0,  6'd0));
    send_word(word_of(OP_ADD,    6'd0,  6'd1));    // out of range, dropped
    send_word(word_of(OP_LIST,   6'd0,  6'd0));
    send_word(word_of(OP_QUERY,  6'd0,  6'd63));
    send_word(word_of(OP_LIST,   6'd63, 6'd0));

    // Zero count: nothing in range.
    write_count(7'd0);
    send_word(word_of(OP_ADD,    6'd0,  6'd0));
    send_word(word_of(OP_QUERY,  6'd0,  6'd0));
    send_word(word_of(OP_LIST,   6'd0,  6'd0));

    // Count above the maximum acts as the maximum.
    write_count(7'd127);
    send_word(word_of(OP_LIST,   6'd63, 6'd0));
    send_word(word_of(OP_QUERY,  6'd63, 6'd63));
    send_word(word_of(OP_LIST,   6'd42, 6'd0));

    // Random phases, one count setting each.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: n = 7'd64;
        1: n = 7'($urandom_range(2, 63));
        2: n = 7'd1;
        3: n = 7'd127;
        4: n = 7'd0;
        5: n = 7'($urandom_range(65, 126));
        6: n = 7'd2;
        default: n = 7'($urandom_range(1, 64));
      endcase
      write_count(n);
      live   = (n > MAX_VERTICES) ? MAX_VERTICES : int'(n);
      target = sent + PHASE_WORDS;
      while (sent < target) begin
        // Now and then build up a hub and list it, for long neighbour runs.
        if (live > 1 && $urandom_range(0, 19) == 0) begin
          hub = 6'($urandom_range(0, live - 1));
          repeat ($urandom_range(4, 16))
            send_word(word_of(OP_ADD, hub, 6'($urandom_range(0, live - 1))));
          send_word(word_of(OP_LIST, hub, 6'($urandom_range(0, 63))));
        end else begin
          send_word(random_word(live));
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("adjacency_matrix_graph_core_tb: done, clean");
    end else begin
      $display("adjacency_matrix_graph_core_tb: done, errors");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #2000000;
    $display("adjacency_matrix_graph_core_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

### adjacency_matrix_graph_core.f
+incdir+rtl
rtl/agm_pkg.sv
rtl/agm_ctrl.sv
rtl/agm_dpath.sv
rtl/adjacency_matrix_graph_core.sv
rtl/agm_checker.sv
tb/adjacency_result_checker.sv
tb/adjacency_matrix_graph_core_tb.sv
